>>> hdl/bpp_pkg.sv
package bpp_pkg;

    localparam int CELL_FIELDS = 6;
    localparam int MV_W        = 16;
    localparam int CUR_W       = 16;
    localparam int TEMP_W      = 8;
    localparam int CMD_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // host commands
    localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE_DSG = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OPEN_DSG  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSE_CHG = 3'd3;
    localparam logic [CMD_W-1:0] CMD_OPEN_CHG  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OV_TRIP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OV_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UV_TRIP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UV_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 3'd5;

    // register reset values
    localparam logic [MV_W-1:0]          RST_OV_TRIP    = 16'd4200;
    localparam logic [MV_W-1:0]          RST_OV_RELEASE = 16'd4000;
    localparam logic [MV_W-1:0]          RST_UV_TRIP    = 16'd2800;
    localparam logic [MV_W-1:0]          RST_UV_RELEASE = 16'd3000;
    localparam logic signed [CUR_W-1:0]  RST_CUR_LIMIT  = 16'sd5000;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_LIMIT = 8'sd35;

    typedef logic [CELL_FIELDS-1:0][MV_W-1:0] t_cells;

    typedef struct packed {
        logic [MV_W-1:0]          ov_trip;
        logic [MV_W-1:0]          ov_release;
        logic [MV_W-1:0]          uv_trip;
        logic [MV_W-1:0]          uv_release;
        logic signed [CUR_W-1:0]  cur_limit;
        logic signed [TEMP_W-1:0] temp_limit;
    } t_cfg;

    typedef struct packed {
        logic chg_on;
        logic dsg_on;
        logic ov;
        logic uv;
        logic oc;
        logic ot;
    } t_prot;

    typedef struct packed {
        t_prot prot;
        logic  clr;
    } t_res;

endpackage

>>> hdl/bpp_cfg.sv
module bpp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bpp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bpp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output bpp_pkg::t_cfg                      o_cfg
);

    bpp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ov_trip    <= bpp_pkg::RST_OV_TRIP;
            r_cfg.ov_release <= bpp_pkg::RST_OV_RELEASE;
            r_cfg.uv_trip    <= bpp_pkg::RST_UV_TRIP;
            r_cfg.uv_release <= bpp_pkg::RST_UV_RELEASE;
            r_cfg.cur_limit  <= bpp_pkg::RST_CUR_LIMIT;
            r_cfg.temp_limit <= bpp_pkg::RST_TEMP_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpp_pkg::REG_OV_TRIP:    r_cfg.ov_trip    <= i_cfg_data;
                bpp_pkg::REG_OV_RELEASE: r_cfg.ov_release <= i_cfg_data;
                bpp_pkg::REG_UV_TRIP:    r_cfg.uv_trip    <= i_cfg_data;
                bpp_pkg::REG_UV_RELEASE: r_cfg.uv_release <= i_cfg_data;
                bpp_pkg::REG_CUR_LIMIT:  r_cfg.cur_limit  <= $signed(i_cfg_data);
                bpp_pkg::REG_TEMP_LIMIT:
                    r_cfg.temp_limit <= $signed(i_cfg_data[bpp_pkg::TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/bpp_core.sv
module bpp_core #(
    parameter int CHK_CELLS = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic [bpp_pkg::CMD_W-1:0]           i_cmd,
    input  bpp_pkg::t_cells                     i_cells,
    input  logic signed [bpp_pkg::CUR_W-1:0]    i_cur,
    input  logic signed [bpp_pkg::TEMP_W-1:0]   i_temp,
    input  bpp_pkg::t_cfg                       i_cfg,
    output bpp_pkg::t_res                       o_res
);

    bpp_pkg::t_prot r_prot;
    bpp_pkg::t_prot n_prot;
    bpp_pkg::t_res  r_res;
    logic           n_clr;
    logic           any_ov;
    logic           all_below;
    logic           any_uv;
    logic           all_above;

    always_comb begin
        any_ov    = 1'b0;
        all_below = 1'b1;
        any_uv    = 1'b0;
        all_above = 1'b1;
        for (int i = 0; i < CHK_CELLS; i++) begin
            if (i_cells[i] > i_cfg.ov_trip)     any_ov    = 1'b1;
            if (i_cells[i] >= i_cfg.ov_release) all_below = 1'b0;
            if (i_cells[i] < i_cfg.uv_trip)     any_uv    = 1'b1;
            if (i_cells[i] <= i_cfg.uv_release) all_above = 1'b0;
        end
    end

    always_comb begin
        n_prot = r_prot;
        n_clr  = 1'b0;

        case (i_cmd)
            bpp_pkg::CMD_CLOSE_DSG: n_prot.dsg_on = 1'b1;
            bpp_pkg::CMD_OPEN_DSG:  n_prot.dsg_on = 1'b0;
            bpp_pkg::CMD_CLOSE_CHG: n_prot.chg_on = 1'b1;
            bpp_pkg::CMD_OPEN_CHG:  n_prot.chg_on = 1'b0;
            default: ;
        endcase

        if (any_ov) begin
            n_prot.chg_on = 1'b0;
            n_prot.ov     = 1'b1;
            n_clr         = 1'b1;
        end
        if (n_prot.ov && all_below) begin
            n_prot.chg_on = 1'b1;
            n_prot.ov     = 1'b0;
            n_clr         = 1'b1;
        end

        if (any_uv) begin
            n_prot.dsg_on = 1'b0;
            n_prot.uv     = 1'b1;
            n_clr         = 1'b1;
        end
        if (n_prot.uv && all_above) begin
            n_prot.dsg_on = 1'b1;
            n_prot.uv     = 1'b0;
            n_clr         = 1'b1;
        end

        if (i_cur > i_cfg.cur_limit) begin
            n_prot.chg_on = 1'b0;
            n_prot.dsg_on = 1'b0;
            n_prot.oc     = 1'b1;
            n_clr         = 1'b1;
        end
        if (n_prot.oc && (i_cur < i_cfg.cur_limit)) begin
            n_prot.chg_on = 1'b1;
            n_prot.dsg_on = 1'b1;
            n_prot.oc     = 1'b0;
            n_clr         = 1'b1;
        end

        if (i_temp > i_cfg.temp_limit) begin
            n_prot.chg_on = 1'b0;
            n_prot.dsg_on = 1'b0;
            n_prot.ot     = 1'b1;
            n_clr         = 1'b1;
        end
        if (n_prot.ot && (i_temp < i_cfg.temp_limit)) begin
            n_prot.chg_on = 1'b1;
            n_prot.dsg_on = 1'b1;
            n_prot.ot     = 1'b0;
            n_clr         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prot <= '0;
        end else if (i_adv) begin
            r_prot <= n_prot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res.prot <= n_prot;
            r_res.clr  <= n_clr;
        end
    end

    assign o_res = r_res;

endmodule

>>> hdl/battery_pack_protection.sv
// Battery pack protection. One word per measurement round: host command, six cell voltages,
// pack current and temperature; one result word per round with both switch states, the four
// latched fault flags and a clear-status pulse. The block takes one word per clock cycle when
// not stalled; the result word passes through the input register, then the result register;
// the only loop is the protection state itself, which updates in the same cycle that reads it.
// Both channels use valid/stall; a result waiting under stall still lets one more word enter.
// Only the first NUM_CELLS cells (at most six) are checked. Thresholds reset to 4200/4000 mV
// overvoltage trip/release, 2800/3000 mV undervoltage trip/release, 5000 mA and 35 C. Users
// must write them through the register port only while idle; the block does not enforce this.
module battery_pack_protection #(
    parameter int NUM_CELLS = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bpp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bpp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bpp_pkg::CMD_W-1:0]           i_cmd,
    input  logic [bpp_pkg::MV_W-1:0]            i_cell_mv_a,
    input  logic [bpp_pkg::MV_W-1:0]            i_cell_mv_b,
    input  logic [bpp_pkg::MV_W-1:0]            i_cell_mv_c,
    input  logic [bpp_pkg::MV_W-1:0]            i_cell_mv_d,
    input  logic [bpp_pkg::MV_W-1:0]            i_cell_mv_e,
    input  logic [bpp_pkg::MV_W-1:0]            i_cell_mv_f,
    input  logic signed [bpp_pkg::CUR_W-1:0]    i_pack_current_ma,
    input  logic signed [bpp_pkg::TEMP_W-1:0]   i_temperature_c,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_charge_enable,
    output logic                                o_discharge_enable,
    output logic                                o_overvoltage_active,
    output logic                                o_undervoltage_active,
    output logic                                o_overcurrent_active,
    output logic                                o_overtemp_active,
    output logic                                o_clear_status
);

    localparam int CHK_CELLS = (NUM_CELLS > bpp_pkg::CELL_FIELDS) ? bpp_pkg::CELL_FIELDS
                                                                   : NUM_CELLS;

    logic                               r_in_vld;
    logic [bpp_pkg::CMD_W-1:0]          r_cmd;
    bpp_pkg::t_cells                    r_cells;
    logic signed [bpp_pkg::CUR_W-1:0]   r_cur;
    logic signed [bpp_pkg::TEMP_W-1:0]  r_temp;
    logic                               r_out_vld;
    logic                               out_ready;
    logic                               adv;
    logic                               in_acc;
    bpp_pkg::t_cfg                      cfg;
    bpp_pkg::t_res                      res;

    assign out_ready  = !r_out_vld || !i_out_stall;
    assign adv        = r_in_vld && out_ready;
    assign o_in_stall = r_in_vld && !out_ready;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (out_ready) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd      <= i_cmd;
            r_cells[0] <= i_cell_mv_a;
            r_cells[1] <= i_cell_mv_b;
            r_cells[2] <= i_cell_mv_c;
            r_cells[3] <= i_cell_mv_d;
            r_cells[4] <= i_cell_mv_e;
            r_cells[5] <= i_cell_mv_f;
            r_cur      <= i_pack_current_ma;
            r_temp     <= i_temperature_c;
        end
    end

    bpp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bpp_core #(
        .CHK_CELLS (CHK_CELLS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cmd   (r_cmd),
        .i_cells (r_cells),
        .i_cur   (r_cur),
        .i_temp  (r_temp),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign o_out_valid           = r_out_vld;
    assign o_charge_enable       = res.prot.chg_on;
    assign o_discharge_enable    = res.prot.dsg_on;
    assign o_overvoltage_active  = res.prot.ov;
    assign o_undervoltage_active = res.prot.uv;
    assign o_overcurrent_active  = res.prot.oc;
    assign o_overtemp_active     = res.prot.ot;
    assign o_clear_status        = res.clr;

endmodule

>>> test/battery_pack_protection_tb.sv
module battery_pack_protection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CHECKED = 6;
    localparam int NOM = 3500;
    localparam int RANDOM_PHASES = 11;
    localparam int WORDS_PER_PHASE = 104;

    typedef logic [bpp_pkg::CMD_W-1:0]         t_cmd;
    typedef logic [bpp_pkg::MV_W-1:0]          t_mv;
    typedef logic signed [bpp_pkg::CUR_W-1:0]  t_cur;
    typedef logic signed [bpp_pkg::TEMP_W-1:0] t_temp;
    typedef logic [bpp_pkg::CFG_IDX_W-1:0]     t_idx;
    typedef logic [bpp_pkg::CFG_DATA_W-1:0]    t_data;

    // command and register codes the block must ignore
    localparam t_cmd CMD_SPARE_5 = 3'd5;
    localparam t_cmd CMD_SPARE_7 = 3'd7;
    localparam t_idx REG_SPARE_6 = 3'd6;
    localparam t_idx REG_SPARE_7 = 3'd7;

    typedef struct packed {
        t_cmd            cmd;
        bpp_pkg::t_cells cells;
        t_cur            cur;
        t_temp           temp;
    } t_round;

    typedef struct {
        t_round        rnd;
        bit            has_exp;
        bpp_pkg::t_res exp_res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    t_idx i_cfg_idx = '0;
    t_data i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_cmd i_cmd = bpp_pkg::CMD_NONE;
    t_mv i_cell_mv_a = '0;
    t_mv i_cell_mv_b = '0;
    t_mv i_cell_mv_c = '0;
    t_mv i_cell_mv_d = '0;
    t_mv i_cell_mv_e = '0;
    t_mv i_cell_mv_f = '0;
    t_cur i_pack_current_ma = '0;
    t_temp i_temperature_c = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_charge_enable;
    logic o_discharge_enable;
    logic o_overvoltage_active;
    logic o_undervoltage_active;
    logic o_overcurrent_active;
    logic o_overtemp_active;
    logic o_clear_status;

    battery_pack_protection #(
        .NUM_CELLS(N_CHECKED)
    ) uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_cmd                (i_cmd),
        .i_cell_mv_a          (i_cell_mv_a),
        .i_cell_mv_b          (i_cell_mv_b),
        .i_cell_mv_c          (i_cell_mv_c),
        .i_cell_mv_d          (i_cell_mv_d),
        .i_cell_mv_e          (i_cell_mv_e),
        .i_cell_mv_f          (i_cell_mv_f),
        .i_pack_current_ma    (i_pack_current_ma),
        .i_temperature_c      (i_temperature_c),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_charge_enable      (o_charge_enable),
        .o_discharge_enable   (o_discharge_enable),
        .o_overvoltage_active (o_overvoltage_active),
        .o_undervoltage_active(o_undervoltage_active),
        .o_overcurrent_active (o_overcurrent_active),
        .o_overtemp_active    (o_overtemp_active),
        .o_clear_status       (o_clear_status)
    );

    always #5 i_clk = ~i_clk;

    // protection model state and thresholds
    bpp_pkg::t_cfg  cfg_q;
    bpp_pkg::t_prot prot_q;
    bpp_pkg::t_res  status_q[$];

    int n_errors = 0;
    int n_rounds = 0;
    int n_checked = 0;
    int n_clear = 0;
    int n_settings = 1;
    int n_trip[4] = '{0, 0, 0, 0};

    string res_fields[0:6] = '{"clear_status", "overtemp_active", "overcurrent_active",
                               "undervoltage_active", "overvoltage_active",
                               "discharge_enable", "charge_enable"};

    task automatic report(input string msg);
        n_errors++;
        if (n_errors <= 50) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic int pick_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic bpp_pkg::t_res step_protection(t_round r);
        bpp_pkg::t_prot p;
        bit any_ov, all_below, any_uv, all_above, clr;
        int cur, lim, tmp, tlim;
        p = prot_q;
        any_ov = 1'b0;
        all_below = 1'b1;
        any_uv = 1'b0;
        all_above = 1'b1;
        clr = 1'b0;
        cur = $signed(r.cur);
        lim = $signed(cfg_q.cur_limit);
        tmp = $signed(r.temp);
        tlim = $signed(cfg_q.temp_limit);
        case (r.cmd)
            bpp_pkg::CMD_CLOSE_DSG: p.dsg_on = 1'b1;
            bpp_pkg::CMD_OPEN_DSG:  p.dsg_on = 1'b0;
            bpp_pkg::CMD_CLOSE_CHG: p.chg_on = 1'b1;
            bpp_pkg::CMD_OPEN_CHG:  p.chg_on = 1'b0;
            default: ;
        endcase
        for (int i = 0; i < N_CHECKED; i++) begin
            if (r.cells[i] > cfg_q.ov_trip) any_ov = 1'b1;
            if (!(r.cells[i] < cfg_q.ov_release)) all_below = 1'b0;
            if (r.cells[i] < cfg_q.uv_trip) any_uv = 1'b1;
            if (!(r.cells[i] > cfg_q.uv_release)) all_above = 1'b0;
        end
        if (any_ov) begin
            p.chg_on = 1'b0;
            p.ov = 1'b1;
            clr = 1'b1;
            n_trip[0]++;
        end
        if (p.ov && all_below) begin
            p.chg_on = 1'b1;
            p.ov = 1'b0;
            clr = 1'b1;
        end
        if (any_uv) begin
            p.dsg_on = 1'b0;
            p.uv = 1'b1;
            clr = 1'b1;
            n_trip[1]++;
        end
        if (p.uv && all_above) begin
            p.dsg_on = 1'b1;
            p.uv = 1'b0;
            clr = 1'b1;
        end
        if (cur > lim) begin
            p.chg_on = 1'b0;
            p.dsg_on = 1'b0;
            p.oc = 1'b1;
            clr = 1'b1;
            n_trip[2]++;
        end
        if (p.oc && cur < lim) begin
            p.chg_on = 1'b1;
            p.dsg_on = 1'b1;
            p.oc = 1'b0;
            clr = 1'b1;
        end
        if (tmp > tlim) begin
            p.chg_on = 1'b0;
            p.dsg_on = 1'b0;
            p.ot = 1'b1;
            clr = 1'b1;
            n_trip[3]++;
        end
        if (p.ot && tmp < tlim) begin
            p.chg_on = 1'b1;
            p.dsg_on = 1'b1;
            p.ot = 1'b0;
            clr = 1'b1;
        end
        prot_q = p;
        return {p, clr};
    endfunction

    // near one of the four voltage thresholds
    function automatic t_mv near_mv();
        int t;
        case ($urandom_range(3))
            0: t = int'(cfg_q.ov_trip);
            1: t = int'(cfg_q.ov_release);
            2: t = int'(cfg_q.uv_trip);
            default: t = int'(cfg_q.uv_release);
        endcase
        return t_mv'(clamp(t + pick_between(-2, 2), 0, 65535));
    endfunction

    // inside the band that neither trips nor blocks a release
    function automatic t_mv calm_mv();
        int lo, hi, ovt, uvt;
        lo = int'(cfg_q.uv_release) + 1;
        uvt = int'(cfg_q.uv_trip);
        if (uvt > lo) lo = uvt;
        hi = int'(cfg_q.ov_release) - 1;
        ovt = int'(cfg_q.ov_trip);
        if (ovt < hi) hi = ovt;
        if (lo <= hi) begin
            return t_mv'(pick_between(lo, hi));
        end
        return t_mv'($urandom_range(65535));
    endfunction

    function automatic int calm_below(int lim, int floor_v, int span);
        int lo;
        if (lim == floor_v) begin
            return pick_between(floor_v, -floor_v - 1);
        end
        lo = ($urandom_range(3) == 0) ? floor_v : clamp(lim - span, floor_v, lim - 1);
        return pick_between(lo, lim - 1);
    endfunction

    function automatic t_round gen_round();
        t_round r;
        int style, k;
        r.cmd = ($urandom_range(1) == 0) ? bpp_pkg::CMD_NONE : t_cmd'($urandom_range(7));
        style = int'($urandom_range(99));
        if (style < 80) begin
            for (int i = 0; i < bpp_pkg::CELL_FIELDS; i++) begin
                r.cells[i] = calm_mv();
            end
            r.cur = t_cur'(calm_below($signed(cfg_q.cur_limit), -32768, 3000));
            r.temp = t_temp'(calm_below($signed(cfg_q.temp_limit), -128, 30));
            if (style >= 35) begin
                repeat ($urandom_range(1, 2)) begin
                    k = int'($urandom_range(7));
                    if (k < bpp_pkg::CELL_FIELDS) begin
                        r.cells[k] = near_mv();
                    end else if (k == 6) begin
                        r.cur = t_cur'(clamp($signed(cfg_q.cur_limit) + pick_between(-2, 2),
                                             -32768, 32767));
                    end else begin
                        r.temp = t_temp'(clamp($signed(cfg_q.temp_limit) + pick_between(-2, 2),
                                               -128, 127));
                    end
                end
            end
        end else begin
            for (int i = 0; i < bpp_pkg::CELL_FIELDS; i++) begin
                r.cells[i] = t_mv'($urandom);
            end
            r.cur = t_cur'($urandom);
            r.temp = t_temp'($urandom);
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = int'($urandom_range(99));
        if (r < 50) return 0;
        if (r < 85) return pick_between(1, 3);
        if (r < 97) return pick_between(4, 12);
        return pick_between(20, 60);
    endfunction

    function automatic t_row mk(t_cmd cmd, int a, int b, int c, int d, int e,
                                int f, int cur, int temp, bit has, logic [6:0] res);
        t_row row;
        row.rnd.cmd = cmd;
        row.rnd.cells[0] = t_mv'(a);
        row.rnd.cells[1] = t_mv'(b);
        row.rnd.cells[2] = t_mv'(c);
        row.rnd.cells[3] = t_mv'(d);
        row.rnd.cells[4] = t_mv'(e);
        row.rnd.cells[5] = t_mv'(f);
        row.rnd.cur = t_cur'(cur);
        row.rnd.temp = t_temp'(temp);
        row.has_exp = has;
        row.exp_res = res;
        return row;
    endfunction

    // receiver: stalls of random length, with long free stretches now and then
    int rx_left = 0;
    always @(negedge i_clk) begin
        if (rx_left > 0) begin
            rx_left--;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            rx_left = ($urandom_range(99) < 75) ? pick_between(0, 6) : pick_between(30, 150);
        end else begin
            i_out_stall <= 1'b1;
            rx_left = gap_len();
        end
    end

    always @(posedge i_clk) begin
        logic [6:0] got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_charge_enable, o_discharge_enable, o_overvoltage_active,
                   o_undervoltage_active, o_overcurrent_active, o_overtemp_active,
                   o_clear_status};
            if (got[0] === 1'b1) n_clear++;
            if (status_q.size() == 0) begin
                report($sformatf("result word %b with nothing expected", got));
            end else begin
                want = status_q.pop_front();
                n_checked++;
                for (int k = 6; k >= 0; k--) begin
                    if (got[k] !== want[k]) begin
                        report($sformatf("result %0d %s got %b want %b", n_checked,
                                         res_fields[k], got[k], want[k]));
                    end
                end
            end
        end
    end

    task automatic send_round(input t_round r, input bit has_exp, input bpp_pkg::t_res typed,
                              input int gap);
        bpp_pkg::t_res pred;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd = r.cmd;
        i_cell_mv_a = r.cells[0];
        i_cell_mv_b = r.cells[1];
        i_cell_mv_c = r.cells[2];
        i_cell_mv_d = r.cells[3];
        i_cell_mv_e = r.cells[4];
        i_cell_mv_f = r.cells[5];
        i_pack_current_ma = r.cur;
        i_temperature_c = r.temp;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pred = step_protection(r);
        status_q.push_back(has_exp ? typed : pred);
        n_rounds++;
        @(negedge i_clk);
    endtask

    // hold off until every expected word is back and the pipeline is quiet
    task automatic settle();
        i_in_valid = 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_idx idx, input t_data data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            bpp_pkg::REG_OV_TRIP:    cfg_q.ov_trip = data;
            bpp_pkg::REG_OV_RELEASE: cfg_q.ov_release = data;
            bpp_pkg::REG_UV_TRIP:    cfg_q.uv_trip = data;
            bpp_pkg::REG_UV_RELEASE: cfg_q.uv_release = data;
            bpp_pkg::REG_CUR_LIMIT:  cfg_q.cur_limit = data;
            bpp_pkg::REG_TEMP_LIMIT: cfg_q.temp_limit = data[bpp_pkg::TEMP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_limits(input bpp_pkg::t_cfg c);
        settle();
        write_reg(bpp_pkg::REG_OV_TRIP, c.ov_trip);
        write_reg(bpp_pkg::REG_OV_RELEASE, c.ov_release);
        write_reg(bpp_pkg::REG_UV_TRIP, c.uv_trip);
        write_reg(bpp_pkg::REG_UV_RELEASE, c.uv_release);
        write_reg(bpp_pkg::REG_CUR_LIMIT, c.cur_limit);
        write_reg(bpp_pkg::REG_TEMP_LIMIT, {8'($urandom_range(255)), c.temp_limit});
        n_settings++;
    endtask

    initial begin
        t_row dir_tab[$];
        bpp_pkg::t_cfg c;
        int burst_left;
        cfg_q = '{bpp_pkg::RST_OV_TRIP, bpp_pkg::RST_OV_RELEASE, bpp_pkg::RST_UV_TRIP,
                  bpp_pkg::RST_UV_RELEASE, bpp_pkg::RST_CUR_LIMIT, bpp_pkg::RST_TEMP_LIMIT};
        prot_q = '0;
        burst_left = 0;

        // result columns: chg dsg ov uv oc ot clr
        dir_tab = '{
            mk(bpp_pkg::CMD_NONE,      NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b0000000),
            mk(bpp_pkg::CMD_CLOSE_DSG, NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b0100000),
            mk(bpp_pkg::CMD_CLOSE_CHG, NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b1100000),
            mk(CMD_SPARE_5,            NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b1100000),
            mk(CMD_SPARE_7,            NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b1100000),
            mk(bpp_pkg::CMD_OPEN_DSG,  NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b1000000),
            mk(bpp_pkg::CMD_OPEN_CHG,  NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b0000000),
            mk(bpp_pkg::CMD_CLOSE_DSG, NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b0100000),
            mk(bpp_pkg::CMD_CLOSE_CHG, NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b1100000),
            mk(bpp_pkg::CMD_NONE, 4201, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b0110001),
            mk(bpp_pkg::CMD_NONE, 4200, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b0110000),
            mk(bpp_pkg::CMD_NONE, 3999, 3999, 3999, 3999, 3999, 3999, 0, 25, 1'b1, 7'b1100001),
            mk(bpp_pkg::CMD_NONE, 3999, 3999, 3999, 3999, 3999, 2799, 0, 25, 1'b1, 7'b1001001),
            mk(bpp_pkg::CMD_NONE, 3999, 3999, 3999, 3999, 3999, 3000, 0, 25, 1'b1, 7'b1001000),
            mk(bpp_pkg::CMD_NONE, 3001, 3001, 3001, 3001, 3001, 3001, 0, 25, 1'b1, 7'b1100001),
            mk(bpp_pkg::CMD_NONE, NOM, 65535, NOM, NOM, 0, NOM, 0, 25, 1'b1, 7'b0011001),
            mk(bpp_pkg::CMD_NONE, NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b1100001),
            mk(bpp_pkg::CMD_NONE, NOM, NOM, NOM, NOM, NOM, NOM, 5001, 25, 1'b1, 7'b0000101),
            mk(bpp_pkg::CMD_NONE, NOM, NOM, NOM, NOM, NOM, NOM, 5000, 25, 1'b1, 7'b0000100),
            mk(bpp_pkg::CMD_NONE, NOM, NOM, NOM, NOM, NOM, NOM, 32767, 25, 1'b1, 7'b0000101),
            mk(bpp_pkg::CMD_NONE, NOM, NOM, NOM, NOM, NOM, NOM, -32768, 25, 1'b1, 7'b1100001),
            mk(bpp_pkg::CMD_NONE, NOM, NOM, NOM, NOM, NOM, NOM, 0, 36, 1'b1, 7'b0000011),
            mk(bpp_pkg::CMD_NONE, NOM, NOM, NOM, NOM, NOM, NOM, 0, 127, 1'b1, 7'b0000011),
            mk(bpp_pkg::CMD_NONE, NOM, NOM, NOM, NOM, NOM, NOM, 0, -128, 1'b1, 7'b1100001),
            mk(bpp_pkg::CMD_NONE, 4300, NOM, NOM, NOM, NOM, NOM, 6000, 25, 1'b1, 7'b0010101),
            // overcurrent release reopens both switches while overvoltage holds
            mk(bpp_pkg::CMD_NONE, 4300, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b0, 7'b0000000),
            mk(bpp_pkg::CMD_NONE, NOM, NOM, NOM, NOM, NOM, NOM, 0, 25, 1'b1, 7'b1100001)
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // writes beyond the register list must leave the thresholds alone
        write_reg(REG_SPARE_6, 16'h0000);
        write_reg(REG_SPARE_7, 16'hFFFF);

        foreach (dir_tab[i]) begin
            send_round(dir_tab[i].rnd, dir_tab[i].has_exp, dir_tab[i].exp_res, gap_len());
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: ;
                1: set_limits('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 8'h80});
                2: set_limits('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 8'h7F});
                // crossed thresholds: trip and release in the same round
                3: set_limits('{16'd1000, 16'd5000, 16'd5000, 16'd1000, 16'h0000, 8'h00});
                RANDOM_PHASES - 1: begin
                    c.ov_trip = t_mv'($urandom);
                    c.ov_release = t_mv'($urandom);
                    c.uv_trip = t_mv'($urandom);
                    c.uv_release = t_mv'($urandom);
                    c.cur_limit = t_cur'($urandom);
                    c.temp_limit = t_temp'($urandom);
                    set_limits(c);
                end
                default: begin
                    c.ov_trip = t_mv'(pick_between(3800, 4600));
                    c.ov_release = t_mv'(int'(c.ov_trip) - pick_between(0, 400));
                    c.uv_trip = t_mv'(pick_between(2000, 3000));
                    c.uv_release = t_mv'(int'(c.uv_trip) + pick_between(0, 400));
                    c.cur_limit = t_cur'(pick_between(-2000, 20000));
                    c.temp_limit = t_temp'(pick_between(-20, 90));
                    set_limits(c);
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (burst_left == 0 && $urandom_range(39) == 0) begin
                    burst_left = pick_between(20, 50);
                end
                if (n == WORDS_PER_PHASE / 2 || $urandom_range(149) == 0) begin
                    settle();
                end
                send_round(gen_round(), 1'b0, '0, (burst_left > 0) ? 0 : gap_len());
                if (burst_left > 0) burst_left--;
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (status_q.size() != 0) begin
            report($sformatf("%0d expected words never arrived", status_q.size()));
        end
        $display("covered %0d rounds under %0d threshold settings, %0d words checked",
                 n_rounds, n_settings, n_checked);
        $display("%0d with clear_status; trip rounds: ov %0d, uv %0d, oc %0d, ot %0d",
                 n_clear, n_trip[0], n_trip[1], n_trip[2], n_trip[3]);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/bpp_pkg.sv
hdl/bpp_cfg.sv
hdl/bpp_core.sv
hdl/battery_pack_protection.sv
test/battery_pack_protection_tb.sv
